// File: hdl/audio_silence_truncator_defines.svh
// assertion macros used by the audio silence truncator port checker
`ifndef AUDIO_SILENCE_TRUNCATOR_DEFINES_SVH
`define AUDIO_SILENCE_TRUNCATOR_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define AST_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("audio silence truncator check failed");

// antecedent at one edge, consequent from the next edge on
`define AST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("audio silence truncator check failed");

`endif

// File: hdl/ast_pkg.sv
// shared types and constants of the audio silence truncator
package ast_pkg;

    localparam int THRESH_W    = 24;
    localparam int ALLOWED_W   = 24;
    localparam int RAMP_CFG_W  = 6;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int COUNT_W     = 25;

    localparam logic [THRESH_W-1:0]   THRESH_RESET  = 24'd0;
    localparam logic [ALLOWED_W-1:0]  ALLOWED_RESET = 24'd9600;
    localparam logic [RAMP_CFG_W-1:0] RAMP_RESET    = 6'd32;
    localparam logic [COUNT_W-1:0]    COUNT_MAX     = {COUNT_W{1'b1}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_ALLOWED   = 2'd1,
        CFG_RAMP      = 2'd2,
        CFG_BYPASS    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DECIDE,
        ST_DISPATCH,
        ST_READ,
        ST_LOAD,
        ST_SAMPLE
    } state_t;

    typedef struct packed {
        logic load;         // latch the accepted input beat
        logic classify;     // silence test and run count update
        logic decide;       // store writes and release plan
        logic rd;           // read one held sample
        logic emit_burst;   // load a held sample into the output register
        logic emit_sample;  // load the current sample into the output register
    } cmd_t;

    typedef struct packed {
        logic burst_pending;
        logic sample_pending;
        logic out_free;
    } status_t;

endpackage

// File: hdl/ast_datapath.sv
// datapath: config registers, run counter, hold memories and output register
module ast_datapath #(
    parameter int RAMP_MAX    = 32,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [ast_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ast_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [SAMPLE_BITS-1:0]         in_sample,
    input  logic                           in_last,
    input  ast_pkg::cmd_t                  cmd,
    output ast_pkg::status_t               status,
    input  logic                           m_tready,
    output logic                           out_valid,
    output logic [SAMPLE_BITS-1:0]         out_sample,
    output logic                           out_last
);
    import ast_pkg::*;

    localparam int PW = (RAMP_MAX > 1) ? $clog2(RAMP_MAX) : 1;
    localparam int RW = $clog2(RAMP_MAX + 1);
    localparam int SW = RW + 1;
    localparam int CW = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(RAMP_MAX - 1);

    logic [THRESH_W-1:0]   thr_reg;
    logic [ALLOWED_W-1:0]  allowed_reg;
    logic [RAMP_CFG_W-1:0] ramp_reg;
    logic                  bypass_reg;

    logic [RW-1:0]         r_reg, r_next;
    logic [ALLOWED_W-1:0]  keep_reg, keep_next;
    logic [RAMP_CFG_W-1:0] ramp_cap, r_full;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   last_reg;
    logic                   silent_reg;
    logic [COUNT_W-1:0]     cnt_reg;
    logic [PW-1:0]          tp_reg;
    logic [PW-1:0]          rd_ptr_reg;
    logic [RW-1:0]          len_reg;
    logic                   src_tail_reg;
    logic                   sample_after_reg;

    logic [SAMPLE_BITS-1:0] head_store [RAMP_MAX];
    logic [SAMPLE_BITS-1:0] tail_ring  [RAMP_MAX];
    logic [SAMPLE_BITS-1:0] head_rd_reg, tail_rd_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_last_reg;

    logic [SAMPLE_BITS-1:0] mag;
    logic                   silent_now;
    logic [COUNT_W-1:0]     d;
    logic [COUNT_W-1:0]     d_m1;
    logic                   le_keep, le_allowed;
    logic [SW-1:0]          tp_w, r_w;
    logic [PW-1:0]          tail_start;
    logic [PW-1:0]          tp_inc, rd_inc;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= THRESH_RESET;
            allowed_reg <= ALLOWED_RESET;
            ramp_reg    <= RAMP_RESET;
            bypass_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD: thr_reg     <= cfg_data[THRESH_W-1:0];
                CFG_ALLOWED:   allowed_reg <= cfg_data[ALLOWED_W-1:0];
                CFG_RAMP:      ramp_reg    <= cfg_data[RAMP_CFG_W-1:0];
                CFG_BYPASS:    bypass_reg  <= cfg_data[0];
                default:       thr_reg     <= thr_reg;
            endcase
        end
    end

    // effective ramp and the count of samples passed at once
    always_comb begin
        ramp_cap  = (ramp_reg > RAMP_CFG_W'(RAMP_MAX)) ? RAMP_CFG_W'(RAMP_MAX) : ramp_reg;
        r_full    = (ALLOWED_W'(ramp_cap) > allowed_reg) ? allowed_reg[RAMP_CFG_W-1:0]
                                                         : ramp_cap;
        r_next    = RW'(r_full);
        keep_next = allowed_reg - ALLOWED_W'(r_next);
    end

    always_ff @(posedge aclk) begin
        r_reg    <= r_next;
        keep_reg <= keep_next;
    end

    always_comb begin
        mag        = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;
        silent_now = CW'(mag) < CW'(thr_reg);
        d          = cnt_reg - COUNT_W'(keep_reg);
        d_m1       = d - COUNT_W'(1);
        le_keep    = cnt_reg <= COUNT_W'(keep_reg);
        le_allowed = cnt_reg <= COUNT_W'(allowed_reg);
        tp_w       = SW'(tp_reg);
        r_w        = SW'(r_reg);
        tail_start = (tp_w >= r_w) ? PW'(tp_w - r_w) : PW'(tp_w + SW'(RAMP_MAX) - r_w);
        tp_inc     = (tp_reg == PTR_LAST) ? '0 : tp_reg + 1'b1;
        rd_inc     = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= in_sample;
            last_reg   <= in_last;
        end
    end

    // run state and release plan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            silent_reg       <= 1'b0;
            cnt_reg          <= '0;
            tp_reg           <= '0;
            rd_ptr_reg       <= '0;
            len_reg          <= '0;
            src_tail_reg     <= 1'b0;
            sample_after_reg <= 1'b0;
        end else begin
            if (cmd.classify) begin
                silent_reg <= silent_now;
                if (!bypass_reg && silent_now && cnt_reg != COUNT_MAX) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.decide) begin
                if (bypass_reg) begin
                    cnt_reg          <= '0;
                    len_reg          <= '0;
                    sample_after_reg <= 1'b1;
                end else if (silent_reg) begin
                    tp_reg           <= tp_inc;
                    sample_after_reg <= le_keep;
                    src_tail_reg     <= 1'b0;
                    rd_ptr_reg       <= '0;
                    if (last_reg) begin
                        cnt_reg <= '0;
                        if (le_keep) begin
                            len_reg <= '0;
                        end else if (le_allowed) begin
                            len_reg <= RW'(d);
                        end else begin
                            len_reg <= r_reg;
                        end
                    end else begin
                        len_reg <= '0;
                    end
                end else begin
                    cnt_reg          <= '0;
                    sample_after_reg <= 1'b1;
                    if (!le_allowed) begin
                        len_reg      <= r_reg;
                        src_tail_reg <= 1'b1;
                        rd_ptr_reg   <= tail_start;
                    end else if (!le_keep) begin
                        len_reg      <= RW'(d);
                        src_tail_reg <= 1'b0;
                        rd_ptr_reg   <= '0;
                    end else begin
                        len_reg <= '0;
                    end
                end
            end
            if (cmd.rd) begin
                rd_ptr_reg <= rd_inc;
                len_reg    <= len_reg - 1'b1;
            end
        end
    end

    // hold memories, registered read
    always_ff @(posedge aclk) begin
        if (cmd.decide && !bypass_reg && silent_reg) begin
            tail_ring[tp_reg] <= sample_reg;
            if (!le_keep && le_allowed) begin
                head_store[PW'(d_m1)] <= sample_reg;
            end
        end
        if (cmd.rd) begin
            head_rd_reg <= head_store[rd_ptr_reg];
            tail_rd_reg <= tail_ring[rd_ptr_reg];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_burst || cmd.emit_sample) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_burst) begin
            out_sample_reg <= src_tail_reg ? tail_rd_reg : head_rd_reg;
            out_last_reg   <= (len_reg == '0) && !sample_after_reg;
        end else if (cmd.emit_sample) begin
            out_sample_reg <= sample_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign status.burst_pending  = (len_reg != '0);
    assign status.sample_pending = sample_after_reg;
    assign status.out_free       = !out_valid_reg || m_tready;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_last   = out_last_reg;

endmodule

// File: hdl/ast_ctrl.sv
// controller state machine sequencing one input beat and its release burst
module ast_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ast_pkg::status_t  status,
    output ast_pkg::cmd_t     cmd
);
    import ast_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                cmd.classify = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                if (status.burst_pending) begin
                    state_next = ST_READ;
                end else if (status.sample_pending) begin
                    state_next = ST_SAMPLE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (status.out_free) begin
                    cmd.emit_burst = 1'b1;
                    state_next     = ST_DISPATCH;
                end
            end
            ST_SAMPLE: begin
                if (status.out_free) begin
                    cmd.emit_sample = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/audio_silence_truncator.sv
// top level of the audio silence truncator
//
// Shortens long runs of silent audio samples. A sample is silent when its
// magnitude is below silence_threshold. In each silent run the first
// (allowed - ramp) samples pass at once and the next ramp samples are held
// in a small head memory; every silent sample also goes into a tail ring.
// A loud sample ends the run: the held head samples (if the run stayed within
// allowed_silent_samples) or the last ramp samples from the tail ring (if it
// grew longer) come out as one burst, followed by the loud sample. At stream
// end (s_tlast) inside a run the first allowed silent samples are kept. Ramp
// is min(ramp_samples, RAMP_MAX, allowed_silent_samples). With bypass set
// every sample passes and the run is cleared. m_tlast marks the last beat
// caused by one input beat; an input that is held or cut causes no beat.
// Sequence: an input beat passes the load, classify, decide and dispatch states;
// when the sample itself passes, a sample state follows, and each released
// held sample takes a dispatch, one memory read and one output load; stalls
// on m_tready add to that. The controller walks the hold memories one entry
// per burst beat. A new input beat is taken while the last result
// still waits in the output register. Configuration writes belong in idle
// time; cfg_ready is always high. There is no clearing pass after reset.
module audio_silence_truncator #(
    parameter int RAMP_MAX    = 32,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ast_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ast_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input samples
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // sample_in, zero pad
    input  logic                              s_tlast,   // last_in
    // kept samples
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,   // sample_out, zero pad
    output logic                              m_tlast    // run_last
);
    import ast_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    cmd_t                   cmd;
    status_t                status;
    logic [SAMPLE_BITS-1:0] out_sample;

    // config is always taken at once
    assign cfg_ready = 1'b1;

    ast_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ast_datapath #(
        .RAMP_MAX    (RAMP_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .in_last    (s_tlast),
        .cmd        (cmd),
        .status     (status),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_sample (out_sample),
        .out_last   (m_tlast)
    );

    // pad bits above the sample are zero
    assign m_tdata = TDATA_W'(out_sample);

endmodule

// File: hdl/ast_checker.sv
// port-level checker for the audio silence truncator and its bind
`include "audio_silence_truncator_defines.svh"

module ast_checker #(
    parameter int TDATA_W = 24
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_ready,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    // a stalled result beat holds
    `AST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // an accepted beat blocks the input while its classify and decide steps run
    `AST_ASSERT_NEXT(a_in_gap, s_tvalid && s_tready, !s_tready ##1 !s_tready)

    // no new input while a burst still has beats to come
    `AST_ASSERT(a_burst_busy, !(m_tvalid && !m_tlast && s_tready))

    // config channel never back-pressures
    `AST_ASSERT(a_cfg_ready, cfg_ready)

endmodule

bind audio_silence_truncator ast_checker #(
    .TDATA_W (((SAMPLE_BITS + 7) / 8) * 8)
) u_ast_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

// File: test/audio_silence_truncator_checker.sv
`timescale 1ns / 1ps
// predictor and result checker for the audio silence truncator
module audio_silence_truncator_checker #(
    parameter int RAMP_MAX    = 32,
    parameter int SAMPLE_BITS = 24,
    parameter int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [ast_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ast_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [DATA_W-1:0]               s_tdata,   // sample_in
    input  logic                            s_tlast,   // last_in
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [DATA_W-1:0]               m_tdata,   // sample_out
    input  logic                            m_tlast,   // run_last
    output int                              fail_count,
    output int                              outstanding
);
    import ast_pkg::*;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef struct packed {
        sample_t sample;
        logic    run_last;
    } kept_t;

    logic [THRESH_W-1:0]   threshold;
    logic [ALLOWED_W-1:0]  allowed;
    logic [RAMP_CFG_W-1:0] ramp;
    logic                  bypass;

    logic [COUNT_W-1:0] run_len;
    sample_t            head_mem [RAMP_MAX];
    sample_t            tail_mem [RAMP_MAX];
    int unsigned        tail_wr;
    kept_t              kept_q [$];
    int                 errors = 0;

    // work out the beats one input sample releases
    function automatic void predict_kept(input sample_t smp, input logic fin);
        sample_t              burst [$];
        logic [SAMPLE_BITS:0] mag;
        int unsigned          r;
        int unsigned          keep;
        int unsigned          top;
        int unsigned          k;
        kept_t                entry;
        r = ramp;
        if (r > RAMP_MAX) r = RAMP_MAX;
        if (r > allowed) r = allowed;
        keep = allowed - r;
        mag = smp[SAMPLE_BITS-1] ? -{1'b1, smp} : {1'b0, smp};
        if (bypass) begin
            run_len = '0;
            burst.push_back(smp);
        end else if (mag < threshold) begin
            if (run_len != COUNT_MAX) run_len = run_len + 1'b1;
            tail_mem[tail_wr] = smp;
            tail_wr = (tail_wr + 1) % RAMP_MAX;
            if (run_len <= keep) begin
                burst.push_back(smp);
            end else if (run_len <= allowed) begin
                head_mem[run_len - keep - 1] = smp;
            end
            if (fin) begin
                if (run_len > keep) begin
                    top = (run_len > allowed) ? allowed : run_len;
                    for (k = 0; k < top - keep && k < RAMP_MAX; k++)
                        burst.push_back(head_mem[k]);
                end
                run_len = '0;
            end
        end else begin
            if (run_len > allowed) begin
                // run grew too long: lead-in comes from the newest silent samples
                for (k = 0; k < r; k++)
                    burst.push_back(tail_mem[(tail_wr + RAMP_MAX - r + k) % RAMP_MAX]);
            end else if (run_len > keep) begin
                for (k = 0; k < run_len - keep && k < RAMP_MAX; k++)
                    burst.push_back(head_mem[k]);
            end
            run_len = '0;
            burst.push_back(smp);
        end
        for (k = 0; k < burst.size(); k++) begin
            entry.sample   = burst[k];
            entry.run_last = (k == burst.size() - 1);
            kept_q.push_back(entry);
        end
    endfunction

    always @(posedge aclk) begin
        kept_t want;
        if (!aresetn) begin
            threshold = THRESH_RESET;
            allowed   = ALLOWED_RESET;
            ramp      = RAMP_RESET;
            bypass    = 1'b0;
            run_len   = '0;
            tail_wr   = 0;
            kept_q.delete();
        end else begin
            // results first: a beat can never be caused by an input of the same edge
            if (m_tvalid && m_tready) begin
                if (kept_q.size() == 0) begin
                    $display("%0t: unexpected beat, sample %h last %b", $time,
                             m_tdata[SAMPLE_BITS-1:0], m_tlast);
                    errors++;
                end else begin
                    want = kept_q.pop_front();
                    if (m_tdata[SAMPLE_BITS-1:0] !== want.sample) begin
                        $display("%0t: sample mismatch, expected %h actual %h", $time,
                                 want.sample, m_tdata[SAMPLE_BITS-1:0]);
                        errors++;
                    end
                    if (m_tlast !== want.run_last) begin
                        $display("%0t: tlast mismatch, expected %b actual %b", $time,
                                 want.run_last, m_tlast);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_THRESHOLD: threshold = cfg_data[THRESH_W-1:0];
                    CFG_ALLOWED:   allowed   = cfg_data[ALLOWED_W-1:0];
                    CFG_RAMP:      ramp      = cfg_data[RAMP_CFG_W-1:0];
                    CFG_BYPASS:    bypass    = cfg_data[0];
                    default:       ;
                endcase
            end
            if (s_tvalid && s_tready) predict_kept(s_tdata[SAMPLE_BITS-1:0], s_tlast);
        end
        fail_count  <= errors;
        outstanding <= kept_q.size();
    end

endmodule

// File: test/audio_silence_truncator_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the audio silence truncator
module audio_silence_truncator_tb;
    import ast_pkg::*;

    localparam int SAMPLE_W      = 24;
    localparam int DATA_W        = ((SAMPLE_W + 7) / 8) * 8;
    localparam int RAMP_LIMIT    = 32;
    // settle time above the longest input beat, one with a full burst of held samples
    localparam int SETTLE_CYCLES = 110;
    // cycles with no beat on any channel before the run is given up
    localparam int STALL_LIMIT   = 4000;
    localparam int unsigned FULL_SCALE = 8388608;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata;    // sample_in
    logic                   s_tlast;    // last_in
    logic                   m_tvalid;
    logic                   m_tready;
    logic [DATA_W-1:0]      m_tdata;    // sample_out
    logic                   m_tlast;    // run_last

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    int items_sent   = 0;
    bit steady       = 1'b0;   // set while neither side may idle

    // settings currently loaded, used to shape the stimulus
    int unsigned cur_thr;
    int unsigned cur_allowed;

    audio_silence_truncator #(
        .RAMP_MAX    (RAMP_LIMIT),
        .SAMPLE_BITS (SAMPLE_W)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    audio_silence_truncator_checker #(
        .RAMP_MAX    (RAMP_LIMIT),
        .SAMPLE_BITS (SAMPLE_W)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver backpressure, about 12 stalled cycles in a hundred
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 12);
    end

    // watchdog: give up after a long stretch with no beat anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // random sender gaps; tasks below are entered just after a rising edge
    task automatic sender_gap();
        while (!steady && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // ready is sampled at the falling edge, where it already shows the next edge
    task automatic send_beat(input logic [SAMPLE_W-1:0] smp, input logic fin);
        sender_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= fin;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
    endtask

    // hold the sender until every predicted beat has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // new settings only once the block is idle; a cut sample may still be in flight
    task automatic configure(input int unsigned thr, input int unsigned allow,
                             input int unsigned rmp, input bit byp);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_ALLOWED, CFG_DATA_W'(allow));
        write_reg(CFG_RAMP, CFG_DATA_W'(rmp));
        write_reg(CFG_BYPASS, CFG_DATA_W'(byp));
        cur_thr     = thr;
        cur_allowed = allow;
    endtask

    // magnitude strictly below the threshold, edges favored
    function automatic logic [SAMPLE_W-1:0] quiet_sample();
        int unsigned m;
        case ($urandom_range(3))
            0:       m = 0;
            1:       m = cur_thr - 1;
            default: m = $urandom_range(cur_thr - 1, 0);
        endcase
        return ($urandom_range(1) != 0) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
    endfunction

    // magnitude at or above the threshold; full scale only exists negative
    function automatic logic [SAMPLE_W-1:0] loud_sample();
        int unsigned m;
        case ($urandom_range(3))
            0:       m = cur_thr;
            1:       m = FULL_SCALE;
            default: m = $urandom_range(FULL_SCALE, cur_thr);
        endcase
        if (m >= FULL_SCALE) return {1'b1, {(SAMPLE_W-1){1'b0}}};
        return ($urandom_range(1) != 0) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
    endfunction

    // one silent run of random length, closed by a loud sample, a stream end
    // or, now and then, arbitrary noise
    task automatic run_sequence();
        int unsigned span;
        int unsigned len;
        int unsigned pick;
        span = (cur_allowed > 40) ? 40 : cur_allowed;
        len  = (cur_thr == 0) ? 0 : $urandom_range(span + 4, 0);
        repeat (len) send_beat(quiet_sample(), 1'b0);
        pick = $urandom_range(9);
        if (pick < 7) begin
            send_beat(loud_sample(), $urandom_range(9) == 0);
        end else if (pick < 9 && cur_thr != 0) begin
            send_beat(quiet_sample(), 1'b1);
        end else begin
            send_beat(SAMPLE_W'($urandom), 1'($urandom_range(1)));
        end
    endtask

    // a phase always closes its stream so no run is open across a settings change
    task automatic run_phase(input int unsigned thr, input int unsigned allow,
                             input int unsigned rmp, input bit byp,
                             input int target, input bit drains);
        int start;
        configure(thr, allow, rmp, byp);
        start = items_sent;
        while (items_sent - start < target) begin
            run_sequence();
            if (drains && $urandom_range(4) == 0) wait_drained();
        end
        send_beat(SAMPLE_W'($urandom), 1'b1);
    endtask

    initial begin
        cfg_valid <= 1'b0;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        aresetn   <= 1'b0;
        cur_thr     = THRESH_RESET;
        cur_allowed = ALLOWED_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: threshold zero, nothing is silent, samples pass as they are
        send_beat(24'h000000, 1'b0);
        send_beat(24'h7fffff, 1'b0);
        send_beat(24'h800000, 1'b0);
        send_beat(24'hffffff, 1'b1);

        // keep two, hold two: short run released from the head memory
        configure(1000, 4, 2, 1'b0);
        send_beat(24'd0, 1'b0);
        send_beat(-24'sd999, 1'b0);
        send_beat(24'd999, 1'b0);
        send_beat(24'd1000, 1'b0);
        // run longer than allowed: lead-in taken from the tail ring
        repeat (6) send_beat(quiet_sample(), 1'b0);
        send_beat(-24'sd1000, 1'b0);
        // stream ends inside a long run: the first allowed samples are kept
        repeat (4) send_beat(quiet_sample(), 1'b0);
        send_beat(quiet_sample(), 1'b1);

        // ramp beyond its maximum and beyond allowed, everything but full scale silent
        configure(FULL_SCALE, 2, 63, 1'b0);
        repeat (3) send_beat(quiet_sample(), 1'b0);
        send_beat(24'h800000, 1'b1);

        // zero allowed: silent samples vanish, the last one of the stream too
        configure(300, 0, 5, 1'b0);
        send_beat(24'd299, 1'b0);
        send_beat(24'd300, 1'b0);
        send_beat(-24'sd299, 1'b1);

        // bypass passes silent and loud alike
        configure(1000, 5, 5, 1'b1);
        send_beat(24'd3, 1'b0);
        send_beat(24'd5000, 1'b1);

        // random part, well-formed runs under many settings
        run_phase(1000, 6, 2, 1'b0, 4, 1'b1);
        steady = 1'b1;
        run_phase(FULL_SCALE, 40, 63, 1'b0, 4, 1'b0);
        steady = 1'b0;
        run_phase(50000, 3, 10, 1'b0, 4, 1'b0);
        run_phase(300, 0, 5, 1'b0, 4, 1'b1);
        run_phase(FULL_SCALE, 24'hffffff, 0, 1'b0, 4, 1'b0);
        run_phase(1000, 5, 5, 1'b1, 4, 1'b0);
        run_phase($urandom_range(FULL_SCALE, 1), $urandom_range(12, 0),
                  $urandom_range(63, 0), 1'b0, 4, 1'b1);
        run_phase(2000, 33, 32, 1'b0, 4, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
